/* rtl/core/tgbc_pkg.sv */
// Package with shared constants and types for the terrain grid clearance block.
`timescale 1ns / 1ps
package tgbc_pkg;

  localparam int STORE_AW = 10;
  localparam int IDX_W    = 8;
  localparam int SC_W     = 58;

  localparam int GRID_ROWS_DEF = 32;
  localparam int GRID_COLS_DEF = 32;

  localparam logic [2:0] CFG_ORIGIN_N = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_E = 3'd1;
  localparam logic [2:0] CFG_CPM      = 3'd2;
  localparam logic [2:0] CFG_MARGIN   = 3'd3;
  localparam logic [2:0] CFG_INV      = 3'd4;

  localparam logic [23:0] CPM_RST    = 24'd13107;
  localparam logic [30:0] MARGIN_RST = 31'd10240;
  localparam logic [31:0] INV_RST    = 32'd6554;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [23:0] PEN_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [16:0]      w;
  } pick_t;

endpackage

/* rtl/core/tgbc_axis.sv */
// Axis pick: cell index, half-cell neighbor pair and Q1.16 weight for one axis.
`timescale 1ns / 1ps
module tgbc_axis #(
  parameter int LEN = tgbc_pkg::GRID_ROWS_DEF
) (
  input  logic signed [tgbc_pkg::SC_W-1:0] scaled,
  output tgbc_pkg::pick_t                  pick
);

  localparam logic [tgbc_pkg::IDX_W-1:0] LAST = tgbc_pkg::IDX_W'(LEN - 1);
  localparam logic signed [tgbc_pkg::SC_W:0] HALF = (tgbc_pkg::SC_W + 1)'(1) <<< 25;
  localparam logic signed [tgbc_pkg::SC_W:0] ONE  = (tgbc_pkg::SC_W + 1)'(1) <<< 26;

  logic [tgbc_pkg::SC_W-27:0]         idx_raw;
  logic [tgbc_pkg::IDX_W-1:0]         idx;
  logic signed [tgbc_pkg::SC_W:0]     delta;
  logic signed [tgbc_pkg::SC_W:0]     dh;
  logic                               below;
  logic [tgbc_pkg::IDX_W-1:0]         base;

  always_comb begin
    idx_raw = scaled[tgbc_pkg::SC_W-1] ? '0 : scaled[tgbc_pkg::SC_W-1:26];
    if (idx_raw > (tgbc_pkg::SC_W - 26)'(LAST)) begin
      idx = LAST;
    end else begin
      idx = idx_raw[tgbc_pkg::IDX_W-1:0];
    end
    delta = {scaled[tgbc_pkg::SC_W-1], scaled}
            - $signed({(tgbc_pkg::SC_W + 1 - tgbc_pkg::IDX_W - 26)'(0), idx, 26'd0});
    below = delta < HALF;
    dh    = below ? delta + HALF : delta - HALF;
    if (dh < 0) begin
      pick.w = '0;
    end else if (dh > ONE) begin
      pick.w = tgbc_pkg::ONE_Q16;
    end else begin
      pick.w = dh[26:10];
    end
    // The neighbor below the first cell is clamped to the grid edge.
    if (below && idx != '0) begin
      base = idx - 1'b1;
    end else begin
      base = idx;
    end
    if (base >= LAST) begin
      pick.lo = LAST;
      pick.hi = LAST;
    end else begin
      pick.lo = base;
      pick.hi = base + 1'b1;
    end
  end

endmodule

/* rtl/core/terrain_grid_bilinear_clearance.sv */
// Top level of the terrain grid bilinear clearance block.
`timescale 1ns / 1ps
// A write word (mode 0) stores one height into the grid and gives no result. A
// query word (mode 1) runs from start through SCALE, PICK, RD0-RD3, BL0-BL2,
// PN1-PN3 and OUT to out_valid: busy stays high meanwhile, and the next word
// is taken in the cycle out_valid shows. The length is set by the single grid
// memory, whose one read port serves the four corner cells one after another,
// and by the blend and penalty multipliers that run one stage a cycle. Results
// are shown for one cycle only; the receiver cannot stall them. Cells must be
// written before a query reads them. No clearing pass runs after reset.
module terrain_grid_bilinear_clearance #(
  parameter int GRID_ROWS = tgbc_pkg::GRID_ROWS_DEF,
  parameter int GRID_COLS = tgbc_pkg::GRID_COLS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_pos_north,
  input  logic signed [31:0] in_pos_east,
  input  logic signed [31:0] in_altitude,
  input  logic [9:0]         in_cell_index,
  input  logic signed [31:0] in_cell_height,
  output logic               out_valid,
  output logic signed [31:0] out_terrain_height,
  output logic [23:0]        out_clearance_penalty,
  output logic [16:0]        out_height_priority,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_RD0   = 4'd3;
  localparam logic [3:0] S_RD1   = 4'd4;
  localparam logic [3:0] S_RD2   = 4'd5;
  localparam logic [3:0] S_RD3   = 4'd6;
  localparam logic [3:0] S_BL0   = 4'd7;
  localparam logic [3:0] S_BL1   = 4'd8;
  localparam logic [3:0] S_BL2   = 4'd9;
  localparam logic [3:0] S_PN1   = 4'd10;
  localparam logic [3:0] S_PN2   = 4'd11;
  localparam logic [3:0] S_PN3   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam int AW = tgbc_pkg::STORE_AW;
  localparam int SW = tgbc_pkg::SC_W;

  // Configuration registers.
  logic signed [31:0] origin_n_r, origin_e_r;
  logic [23:0]        cpm_r;
  logic [30:0]        margin_r;
  logic [31:0]        inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_n_r <= '0;
      origin_e_r <= '0;
      cpm_r      <= tgbc_pkg::CPM_RST;
      margin_r   <= tgbc_pkg::MARGIN_RST;
      inv_r      <= tgbc_pkg::INV_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgbc_pkg::CFG_ORIGIN_N: origin_n_r <= cfg_data;
        tgbc_pkg::CFG_ORIGIN_E: origin_e_r <= cfg_data;
        tgbc_pkg::CFG_CPM:      cpm_r      <= cfg_data[23:0];
        tgbc_pkg::CFG_MARGIN:   margin_r   <= cfg_data[30:0];
        tgbc_pkg::CFG_INV:      inv_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;

  // Height grid: one write port, one registered read port.
  logic [31:0]   grid [2**AW];
  logic [AW-1:0] rd_addr;
  logic [31:0]   grid_q;

  always_ff @(posedge clk) begin
    if (accept && !in_mode) begin
      grid[in_cell_index] <= in_cell_height;
    end
    grid_q <= grid[rd_addr];
  end

  // Query payload registers.
  logic signed [32:0]   rel_n_r, rel_e_r;
  logic signed [31:0]   alt_r;
  logic signed [SW-1:0] scaled_n_r, scaled_e_r;
  tgbc_pkg::pick_t      pick_n, pick_e, pick_n_r, pick_e_r;
  logic signed [31:0]   ca_r, cb_r, cc_r, cd_r, h12_r, h34_r, h_r;
  logic                 short_r, sat_r;
  logic [23:0]          r_r, r2_r;
  logic [23:0]          pen_r;

  tgbc_axis #(.LEN(GRID_ROWS)) u_axis_n (.scaled(scaled_n_r), .pick(pick_n));
  tgbc_axis #(.LEN(GRID_COLS)) u_axis_e (.scaled(scaled_e_r), .pick(pick_e));

  function automatic logic [AW-1:0] cell_addr(input logic [tgbc_pkg::IDX_W-1:0] n,
                                              input logic [tgbc_pkg::IDX_W-1:0] e);
    logic [16:0] lin;
    lin = 17'(n) * 17'(GRID_COLS) + 17'(e);
    return lin[AW-1:0];
  endfunction

  always_comb begin
    unique case (state_r)
      S_RD0:   rd_addr = cell_addr(pick_n_r.lo, pick_e_r.lo);
      S_RD1:   rd_addr = cell_addr(pick_n_r.hi, pick_e_r.lo);
      S_RD2:   rd_addr = cell_addr(pick_n_r.lo, pick_e_r.hi);
      default: rd_addr = cell_addr(pick_n_r.hi, pick_e_r.hi);
    endcase
  end

  // Shared blend unit: a + floor(w * (b - a) / 2^16), exact for the two-term form.
  logic signed [31:0] bl_a, bl_b;
  logic [16:0]        bl_w;
  logic signed [32:0] bl_diff;
  logic signed [50:0] bl_prod;
  logic signed [34:0] bl_sum;
  logic signed [31:0] bl_res;

  always_comb begin
    unique case (state_r)
      S_BL0:   begin bl_a = ca_r;  bl_b = cb_r;   bl_w = pick_n_r.w; end
      S_BL1:   begin bl_a = cc_r;  bl_b = cd_r;   bl_w = pick_n_r.w; end
      default: begin bl_a = h12_r; bl_b = h34_r;  bl_w = pick_e_r.w; end
    endcase
    bl_diff = {bl_b[31], bl_b} - {bl_a[31], bl_a};
    bl_prod = $signed({1'b0, bl_w}) * bl_diff;
    bl_sum  = {{3{bl_a[31]}}, bl_a} + 35'(bl_prod >>> 16);
    bl_res  = bl_sum[31:0];
  end

  // Penalty stages.
  logic signed [32:0] lim;
  logic signed [33:0] shortfall;
  logic [64:0]        p1;
  logic [47:0]        p2, p3;

  always_comb begin
    lim       = {h_r[31], h_r} + $signed({2'b00, margin_r});
    shortfall = {lim[32], lim} - {{2{alt_r[31]}}, alt_r};
    p1        = shortfall[32:0] * inv_r;
    p2        = r_r * r_r;
    p3        = r2_r * r_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_mode) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_PICK;
      S_PICK:  state_nxt = S_RD0;
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_RD3;
      S_RD3:   state_nxt = S_BL0;
      S_BL0:   state_nxt = S_BL1;
      S_BL1:   state_nxt = S_BL2;
      S_BL2:   state_nxt = S_PN1;
      S_PN1:   state_nxt = S_PN2;
      S_PN2:   state_nxt = S_PN3;
      S_PN3:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= state_r == S_OUT;
    end
  end

  // Datapath registers, loaded in the state that produces each value.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        rel_n_r <= {in_pos_north[31], in_pos_north} - {origin_n_r[31], origin_n_r};
        rel_e_r <= {in_pos_east[31], in_pos_east} - {origin_e_r[31], origin_e_r};
        alt_r   <= in_altitude;
      end
      S_SCALE: begin
        // Both factors are widened to the full product width first.
        scaled_n_r <= $signed({{(SW-33){rel_n_r[32]}}, rel_n_r})
                      * $signed({{(SW-24){1'b0}}, cpm_r});
        scaled_e_r <= $signed({{(SW-33){rel_e_r[32]}}, rel_e_r})
                      * $signed({{(SW-24){1'b0}}, cpm_r});
      end
      S_PICK: begin
        pick_n_r <= pick_n;
        pick_e_r <= pick_e;
      end
      S_RD1: ca_r <= grid_q;
      S_RD2: cb_r <= grid_q;
      S_RD3: cc_r <= grid_q;
      S_BL0: begin
        cd_r  <= grid_q;
        h12_r <= bl_res;
      end
      S_BL1: h34_r <= bl_res;
      S_BL2: h_r   <= bl_res;
      S_PN1: begin
        short_r <= $signed({alt_r[31], alt_r}) < lim;
        sat_r   <= |p1[64:34];
        r_r     <= p1[33:10];
      end
      S_PN2: begin
        sat_r <= sat_r || (|p2[47:40]);
        r2_r  <= p2[39:16];
      end
      S_PN3: begin
        if (!short_r) begin
          pen_r <= '0;
        end else if (sat_r || (|p3[47:40])) begin
          pen_r <= tgbc_pkg::PEN_MAX;
        end else begin
          pen_r <= p3[39:16];
        end
      end
      S_OUT: begin
        out_terrain_height    <= h_r;
        out_clearance_penalty <= pen_r;
        out_height_priority   <= (pen_r > 24'(tgbc_pkg::ONE_Q16)) ? 17'd0
                                 : tgbc_pkg::ONE_Q16 - pen_r[16:0];
      end
      default: ;
    endcase
  end

endmodule
